### hw/rtl/thick_slab_projection_unit_assert.svh
// ----------------------------------------------------------------------------
// thick slab projection assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef THICK_SLAB_PROJECTION_UNIT_ASSERT_SVH
`define THICK_SLAB_PROJECTION_UNIT_ASSERT_SVH

// property must hold at every edge outside reset
`define TSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define TSP_ASSERT_NEVER(name, cond, msg) \
  `TSP_ASSERT(name, !(cond), msg)

`endif

### hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// widths, mode codes and the column request type of the slab projection
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int MAX_SLICES  = 1024;
  localparam int SAMPLE_BITS = 16;

  // derived widths
  localparam int COUNT_BITS  = $clog2(MAX_SLICES + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_SLICES);
  localparam int STEP_BITS   = $clog2(SUM_BITS);
  localparam int MODE_BITS   = 2;

  // column request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

  // reduction codes; the unused code acts as maximum
  localparam logic [MODE_BITS-1:0] MODE_MAX   = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_MIN   = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_MEAN  = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_SPARE = MODE_BITS'(3);

  // one finished column, handed from the accumulator to the finisher
  typedef struct packed {
    logic signed [SUM_BITS-1:0] value;
    logic [COUNT_BITS-1:0]      count;
    logic [MODE_BITS-1:0]       mode;
    logic                       too_long;
  } tsp_req_t;

endpackage

### hw/rtl/tsp_if.sv
// ----------------------------------------------------------------------------
// tsp_if
// valid/ready channels for voxel samples and projected pixels
// ----------------------------------------------------------------------------
interface tsp_in_if;
  import tsp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_slice;

  modport source (output valid, sample, last_slice, input ready);
  modport sink (input valid, sample, last_slice, output ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] projected;
  logic                          too_long;

  modport source (output valid, projected, too_long, input ready);
  modport sink (input valid, projected, too_long, output ready);
endinterface

### hw/rtl/thick_slab_projection_unit.sv
// ----------------------------------------------------------------------------
// thick_slab_projection_unit
// reduces one pixel column of slice samples to a max, min or mean value
//
//   channel   dir   payload                        handshake
//   samples   in    sample[15:0], last_slice       valid/ready
//   results   out   projected[15:0], too_long      valid/ready
//   cfg       in    cfg_wr_data[1:0] (mode)        cfg_wr_en, no stall
//
// samples are taken one per cycle; the accumulator stalls only when the
// two-entry column queue is full.
// max and min columns pass straight through the finisher into its output register.
// a mean column holds the finisher while the one-bit-per-cycle divider
// works through every sum bit, and then until the output slot is free.
// rst is synchronous and clears all control state and the mode register.
// a held result does not stop sample intake until the queue fills.
// ----------------------------------------------------------------------------
module thick_slab_projection_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tsp_pkg::MODE_BITS-1:0] cfg_wr_data,
  tsp_in_if.sink                        samples,
  tsp_out_if.source                     results
);
  import tsp_pkg::*;

  logic [MODE_BITS-1:0] projection_mode;
  logic                 push_valid;
  logic                 push_ready;
  tsp_req_t             push_req;
  logic                 pop_valid;
  logic                 pop_ready;
  tsp_req_t             pop_req;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      projection_mode <= MODE_MAX;
    end else if (cfg_wr_en) begin
      projection_mode <= cfg_wr_data;
    end
  end

  // accumulator
  tsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (projection_mode),
    .samples    (samples),
    .push_valid (push_valid),
    .push_req   (push_req),
    .push_ready (push_ready)
  );

  // column request queue
  tsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_req    (pop_req),
    .pop_ready  (pop_ready)
  );

  // finisher
  tsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_req   (pop_req),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

### hw/rtl/tsp_front.sv
// ----------------------------------------------------------------------------
// tsp_front
// column accumulator: running max, min or sum, slice count and overflow flag
// ----------------------------------------------------------------------------
`include "thick_slab_projection_unit_assert.svh"

module tsp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tsp_pkg::MODE_BITS-1:0]   mode,
  tsp_in_if.sink                          samples,
  output logic                            push_valid,
  output tsp_pkg::tsp_req_t               push_req,
  input  logic                            push_ready
);
  import tsp_pkg::*;

  logic signed [SUM_BITS-1:0] running_value;
  logic signed [SUM_BITS-1:0] running_next;
  logic [COUNT_BITS-1:0]      sample_count;
  logic [COUNT_BITS-1:0]      count_next;
  logic                       overflow_seen;
  logic                       overflow_next;
  logic [MODE_BITS-1:0]       column_mode;
  logic [MODE_BITS-1:0]       mode_next;
  logic signed [SUM_BITS-1:0] sample_ext;
  logic                       accept;

  // stall samples only while the request queue is full
  assign samples.ready = push_ready;
  assign accept        = samples.valid && samples.ready;
  assign sample_ext    = SUM_BITS'(samples.sample);

  // column update for the sample on the channel
  always_comb begin
    running_next  = running_value;
    count_next    = sample_count;
    overflow_next = overflow_seen;
    mode_next     = column_mode;
    priority if (sample_count == '0) begin
      mode_next    = mode;
      running_next = sample_ext;
      count_next   = COUNT_BITS'(1);
    end else if (sample_count >= COUNT_BITS'(MAX_SLICES)) begin
      overflow_next = 1'b1;
    end else begin
      unique case (column_mode)
        MODE_MEAN: running_next = running_value + sample_ext;
        MODE_MIN: begin
          if (sample_ext < running_value) running_next = sample_ext;
        end
        default: begin
          if (sample_ext > running_value) running_next = sample_ext;
        end
      endcase
      count_next = sample_count + COUNT_BITS'(1);
    end
  end

  // the last slice hands the finished column to the queue
  assign push_valid = samples.valid && samples.last_slice;
  assign push_req   = '{value: running_next, count: count_next, mode: mode_next,
                        too_long: overflow_next};

  // column state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      column_mode   <= MODE_MAX;
    end else if (accept) begin
      if (samples.last_slice) begin
        running_value <= '0;
        sample_count  <= '0;
        overflow_seen <= 1'b0;
        column_mode   <= MODE_MAX;
      end else begin
        running_value <= running_next;
        sample_count  <= count_next;
        overflow_seen <= overflow_next;
        column_mode   <= mode_next;
      end
    end
  end

  `TSP_ASSERT_NEVER(a_count_bound, sample_count > COUNT_BITS'(MAX_SLICES),
    "slice count above limit")
  `TSP_ASSERT(a_overflow_full, overflow_seen |-> sample_count == COUNT_BITS'(MAX_SLICES),
    "overflow flagged on a column that is not full")

endmodule

### hw/rtl/tsp_queue.sv
// ----------------------------------------------------------------------------
// tsp_queue
// short fifo of finished column requests between accumulator and finisher
// ----------------------------------------------------------------------------
`include "thick_slab_projection_unit_assert.svh"

module tsp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  tsp_pkg::tsp_req_t push_req,
  output logic              push_ready,
  output logic              pop_valid,
  output tsp_pkg::tsp_req_t pop_req,
  input  logic              pop_ready
);
  import tsp_pkg::*;

  tsp_req_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QFILL_BITS-1:0] fill;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = fill != QFILL_BITS'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_req    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + QFILL_BITS'(1);
        2'b01:   fill <= fill - QFILL_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_req;
  end

  `TSP_ASSERT_NEVER(a_fill_range, fill > QFILL_BITS'(QUEUE_DEPTH), "queue fill out of range")

endmodule

### hw/rtl/tsp_back.sv
// ----------------------------------------------------------------------------
// tsp_back
// column finisher: passes max/min through, divides the sum for the mean
// with a radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "thick_slab_projection_unit_assert.svh"

module tsp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  tsp_pkg::tsp_req_t pop_req,
  output logic              pop_ready,
  tsp_out_if.source         results
);
  import tsp_pkg::*;

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t                        state;
  logic [COUNT_BITS-1:0]         divisor;
  logic [COUNT_BITS-1:0]         rem;
  logic [SUM_BITS-1:0]           quot;
  logic [STEP_BITS-1:0]          step;
  logic                          div_done;
  logic                          negate;
  logic                          too_long_hold;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_projected;
  logic                          out_too_long;

  logic                          slot_free;
  logic                          out_load;
  logic [SUM_BITS-1:0]           magnitude;
  logic [COUNT_BITS:0]           rem_sh;
  logic                          q_bit;
  logic [COUNT_BITS-1:0]         rem_step;
  logic [SUM_BITS-1:0]           quot_signed;

  assign slot_free = !out_valid || results.ready;
  assign pop_ready = (state == S_IDLE) && slot_free;

  // a pass-through column or a finished quotient fills the output slot
  assign out_load = ((state == S_IDLE) && pop_valid && pop_ready && (pop_req.mode != MODE_MEAN))
                 || ((state == S_DIV) && div_done && slot_free);

  // magnitude of the column sum
  assign magnitude = pop_req.value[SUM_BITS-1] ? SUM_BITS'(-pop_req.value)
                                               : SUM_BITS'(pop_req.value);

  // one restoring divide step
  always_comb begin
    rem_sh   = {rem, quot[SUM_BITS-1]};
    q_bit    = rem_sh >= {1'b0, divisor};
    rem_step = q_bit ? COUNT_BITS'(rem_sh - {1'b0, divisor}) : COUNT_BITS'(rem_sh);
  end

  // truncation toward zero: sign applied to the quotient of magnitudes
  assign quot_signed = negate ? -quot : quot;

  // sequencer, divider datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid && pop_ready) begin
            if (pop_req.mode == MODE_MEAN) begin
              state         <= S_DIV;
              divisor       <= pop_req.count;
              rem           <= '0;
              quot          <= magnitude;
              negate        <= pop_req.value[SUM_BITS-1];
              too_long_hold <= pop_req.too_long;
              step          <= STEP_BITS'(SUM_BITS - 1);
              div_done      <= 1'b0;
            end else begin
              out_projected <= pop_req.value[SAMPLE_BITS-1:0];
              out_too_long  <= pop_req.too_long;
            end
          end
        end
        S_DIV: begin
          if (!div_done) begin
            rem  <= rem_step;
            quot <= {quot[SUM_BITS-2:0], q_bit};
            if (step == '0) begin
              div_done <= 1'b1;
            end else begin
              step <= step - STEP_BITS'(1);
            end
          end else if (slot_free) begin
            out_projected <= quot_signed[SAMPLE_BITS-1:0];
            out_too_long  <= too_long_hold;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign results.valid     = out_valid;
  assign results.projected = out_projected;
  assign results.too_long  = out_too_long;

  `TSP_ASSERT(a_div_nonzero, state == S_DIV |-> divisor != '0, "mean with zero count")
  `TSP_ASSERT(a_div_finish, (state == S_DIV && div_done && slot_free) |=>
    (state == S_IDLE && out_valid), "finished quotient not delivered")

endmodule
